// ===== rtl/hsv_pkg.sv =====
`default_nettype none

package hsv_pkg;

   localparam int CHANNEL_BITS = 8;
   localparam int HUE_BITS     = 16;

   // Quotient bits produced by the divider chain; both divisions run the same
   // number of steps and keep their top bits.
   localparam int DIV_STEPS  = (HUE_BITS > CHANNEL_BITS) ? HUE_BITS : CHANNEL_BITS;

   // 6*d fits in three extra bits
   localparam int HUE_REM_BITS = CHANNEL_BITS + 3;

   typedef struct packed {
      logic [HUE_REM_BITS-1:0] hue_rem;
      logic [HUE_REM_BITS-1:0] hue_div;
      logic [DIV_STEPS-1:0]    hue_quo;
      logic [CHANNEL_BITS-1:0] sat_rem;
      logic [CHANNEL_BITS-1:0] max_val;
      logic [DIV_STEPS-1:0]    sat_bits;
      logic [DIV_STEPS-1:0]    sat_quo;
      logic                    grey;
   } hsv_pipe_type;

endpackage

`default_nettype wire

// ===== rtl/rgb_to_hsv_color_convert.sv =====
`default_nettype none

// RGB to HSV pixel converter. One pixel is taken on any clock edge with start
// high (busy is always low, so a pixel may be offered every cycle) and its
// result appears on the rsp_ ports, marked by rsp_valid for exactly one cycle,
// once it has passed the front register and the divider stages. The receiver cannot
// stall: it must take every result in the cycle it is shown. The pipe depth is
// set by the divider chain: hue and saturation are each a true division, done
// one quotient bit per pipeline stage, with one front stage ahead of it for
// max/min, chroma and sector selection. Throughput is one pixel per clock.
// Brightness is the largest channel (ties: red, then green); hue is
// floor(2^HUE_BITS * turn fraction), zero for grey; saturation is
// floor(full_scale * chroma / max), zero for grey and black.

module rgb_to_hsv_color_convert (
   input  wire                                clock,
   input  wire                                reset,
   input  wire                                start,
   output logic                               busy,
   input  wire  [hsv_pkg::CHANNEL_BITS-1:0]   req_red,
   input  wire  [hsv_pkg::CHANNEL_BITS-1:0]   req_green,
   input  wire  [hsv_pkg::CHANNEL_BITS-1:0]   req_blue,
   output logic                               rsp_valid,
   output logic [hsv_pkg::HUE_BITS-1:0]       rsp_hue,
   output logic [hsv_pkg::CHANNEL_BITS-1:0]   rsp_saturation,
   output logic [hsv_pkg::CHANNEL_BITS-1:0]   rsp_brightness
);
   import hsv_pkg::*;

   localparam int LATENCY = DIV_STEPS + 1;

   // stage 0 is the front register, stage k holds k quotient bits
   logic         valid_pipe [0:DIV_STEPS];
   hsv_pipe_type data_pipe  [0:DIV_STEPS];
   hsv_pipe_type last;

   // no back pressure anywhere in the pipe
   assign busy = 1'b0;

   hsv_front u_front (
      .clock    (clock),
      .reset    (reset),
      .valid_in (start & ~busy),
      .red      (req_red),
      .green    (req_green),
      .blue     (req_blue),
      .valid_ff (valid_pipe[0]),
      .pipe_ff  (data_pipe[0])
   );

   for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
      hsv_div_stage u_stage (
         .clock    (clock),
         .reset    (reset),
         .valid_in (valid_pipe[k]),
         .pipe_in  (data_pipe[k]),
         .valid_ff (valid_pipe[k+1]),
         .pipe_ff  (data_pipe[k+1])
      );
   end

   assign last = data_pipe[DIV_STEPS];

   // top bits of each quotient; any extra low bits are fraction bits and are dropped
   assign rsp_valid      = valid_pipe[DIV_STEPS];
   assign rsp_hue        = last.grey ? '0 : last.hue_quo[DIV_STEPS-1 -: HUE_BITS];
   assign rsp_saturation = last.grey ? '0 : last.sat_quo[DIV_STEPS-1 -: CHANNEL_BITS];
   assign rsp_brightness = last.max_val;

   // every accepted item comes out after the fixed latency
   a_latency : assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##LATENCY rsp_valid)
      else $error("accepted item did not emerge after pipeline latency");

   // brightness is the max of the channels sampled from the req_ ports at acceptance
   a_max : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_brightness >= $past(req_red, LATENCY)
                  && rsp_brightness >= $past(req_green, LATENCY)
                  && rsp_brightness >= $past(req_blue, LATENCY)))
      else $error("brightness below an input channel");

   // brightness equals one of the channels
   a_max_hit : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_brightness == $past(req_red, LATENCY)
                  || rsp_brightness == $past(req_green, LATENCY)
                  || rsp_brightness == $past(req_blue, LATENCY)))
      else $error("brightness matches no input channel");

   // black pixel gives zero hue and saturation
   a_black : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_brightness == '0) |-> (rsp_hue == '0 && rsp_saturation == '0))
      else $error("black pixel with nonzero hue or saturation");

endmodule

`default_nettype wire

// ===== rtl/hsv_front.sv =====
`default_nettype none

module hsv_front (
   input  wire                                clock,
   input  wire                                reset,
   input  wire                                valid_in,
   input  wire  [hsv_pkg::CHANNEL_BITS-1:0]   red,
   input  wire  [hsv_pkg::CHANNEL_BITS-1:0]   green,
   input  wire  [hsv_pkg::CHANNEL_BITS-1:0]   blue,
   output logic                               valid_ff,
   output hsv_pkg::hsv_pipe_type              pipe_ff
);
   import hsv_pkg::*;

   logic [CHANNEL_BITS-1:0]   mx;
   logic [CHANNEL_BITS-1:0]   mn;
   logic [CHANNEL_BITS-1:0]   d;
   logic [HUE_REM_BITS-1:0]   d_w;
   logic [HUE_REM_BITS-1:0]   r_w;
   logic [HUE_REM_BITS-1:0]   g_w;
   logic [HUE_REM_BITS-1:0]   b_w;
   logic [HUE_REM_BITS-1:0]   d6;
   logic [HUE_REM_BITS-1:0]   num;
   logic [2*CHANNEL_BITS-1:0] sat_x;
   hsv_pipe_type              pipe_in;

   always_comb begin
      r_w = HUE_REM_BITS'(red);
      g_w = HUE_REM_BITS'(green);
      b_w = HUE_REM_BITS'(blue);
      priority if (red >= green && red >= blue) begin
         mx = red;
         mn = (green < blue) ? green : blue;
      end else if (green >= blue) begin
         mx = green;
         mn = (red < blue) ? red : blue;
      end else begin
         mx = blue;
         mn = (red < green) ? red : green;
      end
      d   = mx - mn;
      d_w = HUE_REM_BITS'(d);
      d6  = (d_w << 2) + (d_w << 1);
      // sector offset plus signed channel difference, in [0, 6d) when d is nonzero
      priority if (red >= green && red >= blue) begin
         if (green >= blue) begin
            num = g_w - b_w;
         end else begin
            num = d6 - (b_w - g_w);
         end
      end else if (green >= blue) begin
         num = (d_w << 1) + b_w - r_w;
      end else begin
         num = (d_w << 2) + r_w - g_w;
      end
      // full-scale times chroma
      sat_x = {d, {CHANNEL_BITS{1'b0}}} - (2*CHANNEL_BITS)'(d);

      pipe_in.hue_rem  = num;
      pipe_in.hue_div  = d6;
      pipe_in.hue_quo  = '0;
      pipe_in.sat_rem  = sat_x[2*CHANNEL_BITS-1:CHANNEL_BITS];
      pipe_in.max_val  = mx;
      pipe_in.sat_bits = DIV_STEPS'(sat_x[CHANNEL_BITS-1:0]) << (DIV_STEPS - CHANNEL_BITS);
      pipe_in.sat_quo  = '0;
      pipe_in.grey     = (d == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      pipe_ff <= pipe_in;
   end

endmodule

`default_nettype wire

// ===== rtl/hsv_div_stage.sv =====
`default_nettype none

module hsv_div_stage (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    valid_in,
   input  hsv_pkg::hsv_pipe_type  pipe_in,
   output logic                   valid_ff,
   output hsv_pkg::hsv_pipe_type  pipe_ff
);
   import hsv_pkg::*;

   logic [HUE_REM_BITS:0]   hue_sh;
   logic [HUE_REM_BITS:0]   hue_diff;
   logic                    hue_bit;
   logic [CHANNEL_BITS:0]   sat_sh;
   logic [CHANNEL_BITS:0]   sat_diff;
   logic                    sat_bit;
   hsv_pipe_type            pipe_nx;

   // one restoring step for each quotient
   always_comb begin
      hue_sh   = {pipe_in.hue_rem, 1'b0};
      hue_diff = hue_sh - {1'b0, pipe_in.hue_div};
      hue_bit  = (hue_sh >= {1'b0, pipe_in.hue_div});

      sat_sh   = {pipe_in.sat_rem, pipe_in.sat_bits[DIV_STEPS-1]};
      sat_diff = sat_sh - {1'b0, pipe_in.max_val};
      sat_bit  = (sat_sh >= {1'b0, pipe_in.max_val});

      pipe_nx          = pipe_in;
      pipe_nx.hue_rem  = hue_bit ? hue_diff[HUE_REM_BITS-1:0] : hue_sh[HUE_REM_BITS-1:0];
      pipe_nx.hue_quo  = {pipe_in.hue_quo[DIV_STEPS-2:0], hue_bit};
      pipe_nx.sat_rem  = sat_bit ? sat_diff[CHANNEL_BITS-1:0] : sat_sh[CHANNEL_BITS-1:0];
      pipe_nx.sat_bits = {pipe_in.sat_bits[DIV_STEPS-2:0], 1'b0};
      pipe_nx.sat_quo  = {pipe_in.sat_quo[DIV_STEPS-2:0], sat_bit};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      pipe_ff <= pipe_nx;
   end

endmodule

`default_nettype wire
